[sv/epoch_seconds_to_utc_date_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to UTC date converter
// Clocked on clk; checks are held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_MACROS_SVH

// same-cycle implication
`define ES2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ES2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/es2d_pkg.sv]
// ----------------------------------------------------------------------------
// es2d_pkg
// Shared constants, reciprocal multipliers and month table for the converter.
// ----------------------------------------------------------------------------
package es2d_pkg;

  // pipeline depth, input beat to result beat
  localparam int STAGES = 9;
  typedef logic [STAGES:1] stage_vec_t;

  localparam int EPOCH_W = 38;
  localparam int DAYS_W  = 22;
  localparam int SOD_W   = 17;
  localparam int YEAR_W  = 14;

  // last second of 9999-12-31
  localparam logic [EPOCH_W-1:0] EPOCH_LIMIT = 38'd253402300799;

  // 86400 = 128 * 675: shift off seven bits, then divide by 675
  localparam int DAY_ODD   = 675;
  localparam int DAY_SHIFT = 41;
  localparam logic [31:0] DAY_RECIP =
    32'(((64'd1 << DAY_SHIFT) + 64'(DAY_ODD - 1)) / 64'(DAY_ODD));

  localparam int HOUR_SECS  = 3600;
  localparam int HOUR_SHIFT = 27;
  localparam logic [15:0] HOUR_RECIP =
    16'(((64'd1 << HOUR_SHIFT) + 64'(HOUR_SECS - 1)) / 64'(HOUR_SECS));

  localparam int MIN_SECS  = 60;
  localparam int MIN_SHIFT = 18;
  localparam logic [12:0] MIN_RECIP =
    13'(((64'd1 << MIN_SHIFT) + 64'(MIN_SECS - 1)) / 64'(MIN_SECS));

  localparam int WEEK_DAYS  = 7;
  localparam int WEEK_SHIFT = 25;
  localparam logic [22:0] WEEK_RECIP =
    23'(((64'd1 << WEEK_SHIFT) + 64'(WEEK_DAYS - 1)) / 64'(WEEK_DAYS));
  localparam int EPOCH_WDAY = 4;  // 1970-01-01 was a Thursday

  // days from 1 March of 1 BC to the epoch, less Jan and Feb
  localparam int MAR_OFFSET  = 719527 - 59;
  localparam int CYCLE_DAYS  = 146097;  // 400 Gregorian years
  localparam int YEAR_SHIFT  = 49;
  localparam logic [31:0] YEAR_RECIP =
    32'(((64'd1 << YEAR_SHIFT) + 64'(CYCLE_DAYS - 1)) / 64'(CYCLE_DAYS));

  localparam int C100_SHIFT = 21;
  localparam logic [14:0] C100_RECIP =
    15'(((64'd1 << C100_SHIFT) + 64'd99) / 64'd100);
  localparam int C400_SHIFT = 23;
  localparam logic [14:0] C400_RECIP =
    15'(((64'd1 << C400_SHIFT) + 64'd399) / 64'd400);

  // (yday + 31) * 10 / 306, folded into one multiplier
  localparam int MON_SHIFT = 21;
  localparam logic [16:0] MON_RECIP =
    17'(10 * (((64'd1 << MON_SHIFT) + 64'd305) / 64'd306));

  localparam int MARCH_YDAY_JAN = 306;  // first day of January in a March year

  // 367 * mon / 12 - 30, first March-based day of month mon
  function automatic logic [8:0] month_base(input logic [3:0] mon);
    logic [8:0] b;
    unique case (mon)
      4'd1:    b = 9'd0;
      4'd2:    b = 9'd31;
      4'd3:    b = 9'd61;
      4'd4:    b = 9'd92;
      4'd5:    b = 9'd122;
      4'd6:    b = 9'd153;
      4'd7:    b = 9'd184;
      4'd8:    b = 9'd214;
      4'd9:    b = 9'd245;
      4'd10:   b = 9'd275;
      4'd11:   b = 9'd306;
      4'd12:   b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

[sv/es2d_front.sv]
// ----------------------------------------------------------------------------
// es2d_front
// Stages 1-2: splits seconds into whole days and second of day.
// ----------------------------------------------------------------------------
module es2d_front (
  input  logic                              clk,
  input  es2d_pkg::stage_vec_t              stage_en,
  input  logic [es2d_pkg::EPOCH_W-1:0]      epoch_seconds,
  output logic [es2d_pkg::DAYS_W-1:0]       days,
  output logic [es2d_pkg::SOD_W-1:0]        sod,
  output logic                              oor
);

  logic [62:0]                    day_prod;
  logic [es2d_pkg::DAYS_W-1:0]    q1_r;
  logic [16:0]                    low1_r;
  logic                           oor1_r;
  logic [31:0]                    q_mul;
  logic [9:0]                     rem_hi;
  logic [es2d_pkg::DAYS_W-1:0]    days2_r;
  logic [es2d_pkg::SOD_W-1:0]     sod2_r;
  logic                           oor2_r;

  assign day_prod = 63'(epoch_seconds[37:7]) * 63'(es2d_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      q1_r   <= day_prod[62:es2d_pkg::DAY_SHIFT];
      low1_r <= epoch_seconds[16:0];
      oor1_r <= epoch_seconds > es2d_pkg::EPOCH_LIMIT;
    end
  end

  // remainder of (n >> 7) / 675 is below 1024, so ten bits suffice
  assign q_mul  = 32'(q1_r) * 32'(es2d_pkg::DAY_ODD);
  assign rem_hi = low1_r[16:7] - q_mul[9:0];

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      days2_r <= q1_r;
      sod2_r  <= {rem_hi[9:0], low1_r[6:0]};
      oor2_r  <= oor1_r;
    end
  end

  assign days = days2_r;
  assign sod  = sod2_r;
  assign oor  = oor2_r;

endmodule

[sv/es2d_clock.sv]
// ----------------------------------------------------------------------------
// es2d_clock
// Stages 3-9: hour, minute, second and weekday lane.
// ----------------------------------------------------------------------------
module es2d_clock (
  input  logic                         clk,
  input  es2d_pkg::stage_vec_t         stage_en,
  input  logic [es2d_pkg::DAYS_W-1:0]  days,
  input  logic [es2d_pkg::SOD_W-1:0]   sod,
  output logic [4:0]                   hour,
  output logic [5:0]                   minute,
  output logic [5:0]                   second,
  output logic [2:0]                   weekday
);

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
  } tod_t;

  logic [32:0]                   hour_prod;
  logic [es2d_pkg::DAYS_W-1:0]   wk_num;
  logic [44:0]                   wk_prod;
  logic [4:0]                    hour3_r;
  logic [es2d_pkg::SOD_W-1:0]    sod3_r;
  logic [19:0]                   q7_r;
  logic [2:0]                    wlo3_r;

  logic [es2d_pkg::SOD_W-1:0]    hour_secs;
  logic [5:0]                    q7_mul;
  logic [4:0]                    hour4_r;
  logic [11:0]                   rem4_r;
  logic [2:0]                    wd4_r;

  logic [24:0]                   min_prod;
  logic [4:0]                    hour5_r;
  logic [5:0]                    min5_r;
  logic [11:0]                   rem5_r;
  logic [2:0]                    wd5_r;

  logic [11:0]                   min_secs;
  tod_t                          tod6_r, tod7_r, tod8_r, tod9_r;

  // stage 3: reciprocal multiplies for hour and day/7
  assign hour_prod = 33'(sod) * 33'(es2d_pkg::HOUR_RECIP);
  assign wk_num    = days + es2d_pkg::DAYS_W'(es2d_pkg::EPOCH_WDAY);
  assign wk_prod   = 45'(wk_num) * 45'(es2d_pkg::WEEK_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      hour3_r <= hour_prod[31:es2d_pkg::HOUR_SHIFT];
      sod3_r  <= sod;
      q7_r    <= wk_prod[44:es2d_pkg::WEEK_SHIFT];
      wlo3_r  <= wk_num[2:0];
    end
  end

  // stage 4: remainders; both fit their low bits
  assign hour_secs = es2d_pkg::SOD_W'(hour3_r) * es2d_pkg::SOD_W'(es2d_pkg::HOUR_SECS);
  assign q7_mul    = 6'(q7_r[2:0]) * 6'(es2d_pkg::WEEK_DAYS);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      hour4_r <= hour3_r;
      rem4_r  <= 12'(sod3_r - hour_secs);
      wd4_r   <= wlo3_r - q7_mul[2:0];
    end
  end

  // stage 5: minute
  assign min_prod = 25'(rem4_r) * 25'(es2d_pkg::MIN_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      hour5_r <= hour4_r;
      min5_r  <= min_prod[23:es2d_pkg::MIN_SHIFT];
      rem5_r  <= rem4_r;
      wd5_r   <= wd4_r;
    end
  end

  // stage 6: second
  assign min_secs = 12'(min5_r) * 12'(es2d_pkg::MIN_SECS);

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      tod6_r.hour    <= hour5_r;
      tod6_r.minute  <= min5_r;
      tod6_r.second  <= 6'(rem5_r - min_secs);
      tod6_r.weekday <= wd5_r;
    end
  end

  // stages 7-9: match the date lane
  always_ff @(posedge clk) begin
    if (stage_en[7]) tod7_r <= tod6_r;
    if (stage_en[8]) tod8_r <= tod7_r;
    if (stage_en[9]) tod9_r <= tod8_r;
  end

  assign hour    = tod9_r.hour;
  assign minute  = tod9_r.minute;
  assign second  = tod9_r.second;
  assign weekday = tod9_r.weekday;

endmodule

[sv/es2d_date.sv]
// ----------------------------------------------------------------------------
// es2d_date
// Stages 3-9: year, month and day of month from the day count.
// ----------------------------------------------------------------------------
module es2d_date (
  input  logic                         clk,
  input  es2d_pkg::stage_vec_t         stage_en,
  input  logic [es2d_pkg::DAYS_W-1:0]  days,
  input  logic                         oor_in,
  output logic [4:0]                   day_of_month,
  output logic [3:0]                   month,
  output logic [es2d_pkg::YEAR_W-1:0]  year,
  output logic                         oor
);

  localparam int YW = es2d_pkg::YEAR_W;
  localparam int DW = es2d_pkg::DAYS_W;

  logic [DW-1:0]   d3_r;
  logic [30:0]     x3_r;
  logic            oor3_r;

  logic [62:0]     year_prod;
  logic [YW-1:0]   y4_r;
  logic [DW-1:0]   d4_r;
  logic            oor4_r;

  logic [28:0]     c100_prod, c400_prod;
  logic [YW-1:0]   y5_r;
  logic [DW-1:0]   d5_r;
  logic [7:0]      q100_5_r;
  logic [5:0]      q400_5_r;
  logic            oor5_r;

  logic [DW:0]     yr_base;
  logic [DW:0]     yd_diff;
  logic [YW-1:0]   y100, y400;
  logic            leap;
  logic [11:0]     yday6_r;
  logic            leap6_r;
  logic [YW-1:0]   y6_r;
  logic            oor6_r;

  logic [8:0]      yday7_r;
  logic [YW-1:0]   y7_r;
  logic            oor7_r;

  logic [25:0]     mon_prod;
  logic [8:0]      yday8_r;
  logic [3:0]      mon8_r;
  logic [YW-1:0]   y8_r;
  logic            oor8_r;

  logic [8:0]      mday_full;
  logic [4:0]      mday9_r;
  logic [3:0]      mon9_r;
  logic [YW-1:0]   y9_r;
  logic            oor9_r;

  // stage 3: days from 1 March 1 BC, and the scaled year numerator
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      d3_r   <= days + DW'(es2d_pkg::MAR_OFFSET);
      x3_r   <= 31'(days + DW'(es2d_pkg::MAR_OFFSET + 2)) * 31'd400;
      oor3_r <= oor_in;
    end
  end

  // stage 4: year estimate, x / 146097
  assign year_prod = 63'(x3_r) * 63'(es2d_pkg::YEAR_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      y4_r   <= year_prod[62:es2d_pkg::YEAR_SHIFT];
      d4_r   <= d3_r;
      oor4_r <= oor3_r;
    end
  end

  // stage 5: century and quad-century counts
  assign c100_prod = 29'(y4_r) * 29'(es2d_pkg::C100_RECIP);
  assign c400_prod = 29'(y4_r) * 29'(es2d_pkg::C400_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      y5_r     <= y4_r;
      d5_r     <= d4_r;
      q100_5_r <= c100_prod[28:es2d_pkg::C100_SHIFT];
      q400_5_r <= c400_prod[28:es2d_pkg::C400_SHIFT];
      oor5_r   <= oor4_r;
    end
  end

  // stage 6: day of year against the estimate, and leap test
  assign yr_base = (DW+1)'(y5_r) * (DW+1)'(365) + (DW+1)'(y5_r[YW-1:2])
                 - (DW+1)'(q100_5_r) + (DW+1)'(q400_5_r);
  assign yd_diff = (DW+1)'(d5_r) - yr_base;
  assign y100    = YW'(q100_5_r) * YW'(100);
  assign y400    = YW'(q400_5_r) * YW'(400);
  assign leap    = (y5_r[1:0] == 2'd0) && ((y5_r != y100) || (y5_r == y400));

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      yday6_r <= yd_diff[11:0];
      leap6_r <= leap;
      y6_r    <= y5_r;
      oor6_r  <= oor5_r;
    end
  end

  // stage 7: estimate one year high, step back
  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      if (yday6_r[11]) begin
        yday7_r <= 9'(yday6_r + 12'd365 + 12'(leap6_r));
        y7_r    <= y6_r - YW'(1);
      end else begin
        yday7_r <= yday6_r[8:0];
        y7_r    <= y6_r;
      end
      oor7_r <= oor6_r;
    end
  end

  // stage 8: March-based month
  assign mon_prod = 26'(10'(yday7_r) + 10'd31) * 26'(es2d_pkg::MON_RECIP);

  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      yday8_r <= yday7_r;
      mon8_r  <= mon_prod[24:es2d_pkg::MON_SHIFT];
      y8_r    <= y7_r;
      oor8_r  <= oor7_r;
    end
  end

  // stage 9: day of month, Jan/Feb fold into next year
  assign mday_full = yday8_r - es2d_pkg::month_base(mon8_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (stage_en[9]) begin
      mday9_r <= mday_full[4:0];
      if (yday8_r >= 9'(es2d_pkg::MARCH_YDAY_JAN)) begin
        mon9_r <= mon8_r - 4'd10;
        y9_r   <= y8_r + YW'(1);
      end else begin
        mon9_r <= mon8_r + 4'd2;
        y9_r   <= y8_r;
      end
      oor9_r <= oor8_r;
    end
  end

  assign day_of_month = mday9_r;
  assign month        = mon9_r;
  assign year         = y9_r;
  assign oor          = oor9_r;

endmodule

[sv/epoch_seconds_to_utc_date.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date: seconds since 1970 to UTC calendar fields
// Pipeline: nine registered stages from input beat to result beat.
// Throughput: one beat per cycle unless a full pipeline is held by out_ready.
// Reset: synchronous, active-low rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
//
// Stage map:
//   1-2   day / second-of-day split (reciprocal of 675 after a 7-bit shift)
//   3-6   time of day and weekday, in parallel with
//   3-9   year estimate, leap correction, month and day of month
// Every stage holds its own valid bit. A stage loads when it is empty or
// when the stage after it loads, so bubbles close up under back-pressure
// and a new beat is taken while a finished result waits, if any stage is empty.
// Beyond 9999-12-31 23:59:59 the flag is raised and all fields read zero.
module epoch_seconds_to_utc_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [37:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [2:0]  out_weekday,
  output logic        out_out_of_range
);

  localparam int N = es2d_pkg::STAGES;

  es2d_pkg::stage_vec_t              valid_r;
  es2d_pkg::stage_vec_t              stage_en;
  logic [es2d_pkg::DAYS_W-1:0]       days;
  logic [es2d_pkg::SOD_W-1:0]        sod;
  logic                              oor_front;
  logic                              oor_last;
  logic [4:0]                        hour, mday;
  logic [5:0]                        minute, second;
  logic [2:0]                        weekday;
  logic [3:0]                        month;
  logic [es2d_pkg::YEAR_W-1:0]       year;

  // stage k may load unless it and every stage after it are full and
  // the sink is stalling
  for (genvar k = 1; k <= N; k++) begin : g_en
    assign stage_en[k] = out_ready | ~(&valid_r[N:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (stage_en[1]) valid_r[1] <= in_valid;
      for (int k = 2; k <= N; k++) begin
        if (stage_en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  assign in_ready  = stage_en[1];
  assign out_valid = valid_r[N];

  es2d_front u_front (
    .clk           (clk),
    .stage_en      (stage_en),
    .epoch_seconds (in_epoch_seconds),
    .days          (days),
    .sod           (sod),
    .oor           (oor_front)
  );

  es2d_clock u_clock (
    .clk      (clk),
    .stage_en (stage_en),
    .days     (days),
    .sod      (sod),
    .hour     (hour),
    .minute   (minute),
    .second   (second),
    .weekday  (weekday)
  );

  es2d_date u_date (
    .clk          (clk),
    .stage_en     (stage_en),
    .days         (days),
    .oor_in       (oor_front),
    .day_of_month (mday),
    .month        (month),
    .year         (year),
    .oor          (oor_last)
  );

  // out-of-range beats carry all-zero fields
  assign out_second       = oor_last ? '0 : second;
  assign out_minute       = oor_last ? '0 : minute;
  assign out_hour         = oor_last ? '0 : hour;
  assign out_day_of_month = oor_last ? '0 : mday;
  assign out_month        = oor_last ? '0 : month;
  assign out_year         = oor_last ? '0 : year;
  assign out_weekday      = oor_last ? '0 : weekday;
  assign out_out_of_range = oor_last;

endmodule

[sv/es2d_checker.sv]
// ----------------------------------------------------------------------------
// es2d_checker
// Port-level checks on beat accounting and output hold, bound to the top.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_utc_date_macros.svh"

module es2d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_second,
  input logic [5:0]  out_minute,
  input logic [4:0]  out_hour,
  input logic [4:0]  out_day_of_month,
  input logic [3:0]  out_month,
  input logic [13:0] out_year,
  input logic [2:0]  out_weekday,
  input logic        out_out_of_range
);

  logic        in_beat, out_beat;
  logic        out_stall;
  logic [43:0] out_bus;
  logic [3:0]  inflight_r, inflight_nxt;

  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;

  // every result field, so a stalled beat is checked whole
  assign out_bus = {out_second, out_minute, out_hour, out_day_of_month, out_month,
                    out_year, out_weekday, out_out_of_range};

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_beat && !out_beat) inflight_nxt = inflight_r + 4'd1;
    if (!in_beat && out_beat) inflight_nxt = inflight_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `ES2D_ASSERT_IMP(a_no_phantom, out_valid, inflight_r != 4'd0, "result with none in flight")
  `ES2D_ASSERT_IMP(a_depth, 1'b1, inflight_r <= 4'(es2d_pkg::STAGES), "too many in flight")
  `ES2D_ASSERT_IMP(a_take_while_wait, out_valid && inflight_r == 4'd1, in_ready, "input refused")
  `ES2D_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_bus), "held result changed")

endmodule

bind epoch_seconds_to_utc_date es2d_checker u_es2d_checker (.*);
